// File: src/sorted_unique_id_set_insert_unit_defines.svh
// Assertion macros for the sorted unique id set insert unit
`ifndef SORTED_UNIQUE_ID_SET_INSERT_UNIT_DEFINES_SVH
`define SORTED_UNIQUE_ID_SET_INSERT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SUIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SUIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SUIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define SUIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/suis_pkg.sv
// Shared types, codes and defaults for the sorted unique id set insert unit
package suis_pkg;

    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } op_code_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_READ_OOR = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_CMP,
        S_RDWAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    rd_index;
        logic    rd_item;
        logic    step;
        logic    append;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic op_insert;
        logic op_clear;
        logic full;
        logic at_end;
        logic match;
        logic placed;
        logic in_range;
        logic out_free;
    } sts_t;

endpackage

// File: src/suis_ctrl.sv
// Controller state machine for the sorted unique id set insert unit
module suis_ctrl
    import suis_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= ST_CLEARED;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.op_insert) begin
                    if (sts.full) begin
                        kind_next  = ST_FULL;
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else if (sts.op_clear) begin
                    kind_next  = ST_CLEARED;
                    state_next = S_FINISH;
                end else if (sts.in_range) begin
                    kind_next  = ST_READ_OK;
                    state_next = S_RDWAIT;
                end else begin
                    kind_next  = ST_READ_OOR;
                    state_next = S_FINISH;
                end
            end
            S_SCAN: begin
                if (sts.at_end) begin
                    kind_next  = ST_INSERTED;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (sts.match && !sts.placed) begin
                    kind_next  = ST_PRESENT;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_RDWAIT: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.out_status = kind_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DECIDE: begin
                cmd.clear    = sts.op_clear;
                cmd.rd_index = !sts.op_insert && !sts.op_clear && sts.in_range;
            end
            S_SCAN: begin
                cmd.append  = sts.at_end;
                cmd.rd_item = !sts.at_end;
            end
            S_CMP: begin
                cmd.step = !(sts.match && !sts.placed);
            end
            S_RDWAIT: begin
                cmd.out_load = 1'b0;
            end
            S_FINISH: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/suis_datapath.sv
// Datapath: id memory, scan registers, entry count and result register
module suis_datapath
    import suis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_id,
    input  logic [5:0]  s_index,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [2:0]  m_status,
    output logic [5:0]  m_position,
    output logic [6:0]  m_entry_count,
    output logic [15:0] m_read_value
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [15:0]      mem [DEPTH];
    logic [15:0]      rdata_reg;
    logic [1:0]       op_reg;
    logic [15:0]      id_reg;
    logic [5:0]       index_reg;
    logic [CNT_W-1:0] count_reg;
    logic [AW-1:0]    j_reg;
    logic [AW-1:0]    pos_reg;
    logic [15:0]      hold_reg;
    logic             placed_reg;

    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic [5:0]       m_position_reg;
    logic [6:0]       m_entry_count_reg;
    logic [15:0]      m_read_value_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [15:0]      wr_data;
    logic             less;
    logic [5:0]       pos_out;

    assign less    = id_reg < rdata_reg;
    assign rd_en   = cmd.rd_index | cmd.rd_item;
    assign rd_addr = cmd.rd_index ? AW'(index_reg) : j_reg;
    assign wr_en   = cmd.append | (cmd.step & (placed_reg | less));
    assign wr_data = placed_reg ? hold_reg : id_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[j_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            id_reg    <= s_id;
            index_reg <= s_index;
        end
        if (cmd.step && (placed_reg || less)) begin
            hold_reg <= rdata_reg;
        end
        if (cmd.step && !placed_reg && less) begin
            pos_reg <= j_reg;
        end else if (cmd.append && !placed_reg) begin
            pos_reg <= j_reg;
        end
        if (cmd.load) begin
            j_reg <= '0;
        end else if (cmd.step) begin
            j_reg <= j_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            placed_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.append) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                placed_reg <= 1'b0;
            end else if (cmd.step && less) begin
                placed_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        case (cmd.out_status)
            ST_PRESENT:              pos_out = 6'(j_reg);
            ST_INSERTED:             pos_out = 6'(pos_reg);
            ST_READ_OK, ST_READ_OOR: pos_out = index_reg;
            default:                 pos_out = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg      <= cmd.out_status;
            m_position_reg    <= pos_out;
            m_entry_count_reg <= 7'(count_reg);
            m_read_value_reg  <= (cmd.out_status == ST_READ_OK) ? rdata_reg : 16'd0;
        end
    end

    assign sts.op_insert = op_reg == OP_INSERT;
    assign sts.op_clear  = op_reg == OP_CLEAR;
    assign sts.full      = count_reg == CNT_W'(DEPTH);
    assign sts.at_end    = CNT_W'(j_reg) == count_reg;
    assign sts.match     = rdata_reg == id_reg;
    assign sts.placed    = placed_reg;
    assign sts.in_range  = (32'(index_reg) < 32'(count_reg)) && (32'(index_reg) < DEPTH);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_position    = m_position_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_read_value  = m_read_value_reg;

endmodule

// File: src/sorted_unique_id_set_insert_unit.sv
// Top level: sorted unique id set insert unit, one transaction at a time.
// Acceptance to m_valid: a new id reads and compares or shifts each held entry, then appends;
// a duplicate stops at its match; clear, full and out-of-range read go straight to S_FINISH;
// an in-range read waits in S_RDWAIT first. s_ready returns with m_valid, so no new
// transaction is taken before the last result; a result waiting on m_ready stalls the next.
// aresetn (synchronous) empties the list and drops m_valid; the id memory is not cleared.
`include "sorted_unique_id_set_insert_unit_defines.svh"
module sorted_unique_id_set_insert_unit
    import suis_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_id,
    input  logic [5:0]  s_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [5:0]  m_position,
    output logic [6:0]  m_entry_count,
    output logic [15:0] m_read_value
);

    cmd_t cmd;
    sts_t sts;

    suis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    suis_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_operation   (s_operation),
        .s_id          (s_id),
        .s_index       (s_index),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_entry_count (m_entry_count),
        .m_read_value  (m_read_value)
    );

    `SUIS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
        "second transaction accepted while busy")
    `SUIS_ASSERT_IMPLY(a_clear_empties, aclk, aresetn,
        m_valid && (m_status == ST_CLEARED), m_entry_count == 7'd0,
        "clear result with entries held")
    `SUIS_ASSERT_IMPLY(a_value_only_on_read, aclk, aresetn,
        m_valid && (m_status != ST_READ_OK), m_read_value == 16'd0,
        "read value on non-read result")

endmodule

// File: tb/sorted_unique_id_set_insert_unit_test.sv
// Self-checking testbench for the sorted unique id set insert unit
module sorted_unique_id_set_insert_unit_test;
    import suis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_DEPTH = DEPTH_DEFAULT;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, decodes as a read
    localparam int DRAIN_CYCLES = 2 * SET_DEPTH + 12;

    typedef struct packed {
        status_t     status;
        logic [5:0]  position;
        logic [6:0]  entry_count;
        logic [15:0] read_value;
    } set_outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [15:0] s_id;
    logic [5:0]  s_index;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [5:0]  m_position;
    logic [6:0]  m_entry_count;
    logic [15:0] m_read_value;

    logic [15:0]  shadow_ids [0:SET_DEPTH-1];
    int           shadow_count;
    set_outcome_t pending_outcomes[$];
    int unsigned  mismatch_count;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  hold_off_left;

    sorted_unique_id_set_insert_unit #(
        .DEPTH(SET_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_id         (s_id),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_position   (m_position),
        .m_entry_count(m_entry_count),
        .m_read_value (m_read_value)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Applies one transaction to the shadow list and returns what the unit should report.
    function automatic set_outcome_t predict_set_outcome(input logic [1:0] op,
                                                         input logic [15:0] id,
                                                         input logic [5:0] idx);
        set_outcome_t r;
        int j;
        r.status     = ST_READ_OOR;
        r.position   = '0;
        r.read_value = '0;
        if (op == OP_INSERT) begin
            if (shadow_count >= SET_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                j = 0;
                while (j < shadow_count && shadow_ids[j] < id) j++;
                r.position = j[5:0];
                if (j < shadow_count && shadow_ids[j] == id) begin
                    r.status = ST_PRESENT;
                end else begin
                    for (int k = shadow_count; k > j; k--) shadow_ids[k] = shadow_ids[k-1];
                    shadow_ids[j] = id;
                    shadow_count++;
                    r.status = ST_INSERTED;
                end
            end
        end else if (op == OP_CLEAR) begin
            shadow_count = 0;
            r.status = ST_CLEARED;
        end else begin
            r.position = idx;
            if (idx < shadow_count) begin
                r.status     = ST_READ_OK;
                r.read_value = shadow_ids[idx];
            end
        end
        r.entry_count = shadow_count[6:0];
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                             input logic [5:0] idx);
        @(negedge aclk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_id        <= id;
        s_index     <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(predict_set_outcome(op, id, idx));
    endtask

    // Receiver: random stalls, or a counted hold-off when requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else begin
                m_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        set_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result status=%0d position=%0d count=%0d value=%h",
                         $time, m_status, m_position, m_entry_count, m_read_value);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_status);
                    mismatch_count++;
                end
                if (m_position !== want.position) begin
                    $display("%0t: position expected %0d got %0d",
                             $time, want.position, m_position);
                    mismatch_count++;
                end
                if (m_entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d got %0d",
                             $time, want.entry_count, m_entry_count);
                    mismatch_count++;
                end
                if (m_read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h got %h",
                             $time, want.read_value, m_read_value);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed_cases;
        send_item(OP_CLEAR,  16'h0000, 6'd0);
        send_item(OP_READ,   16'h0000, 6'd0);     // empty list
        send_item(OP_INSERT, 16'h8000, 6'd0);
        send_item(OP_INSERT, 16'hFFFF, 6'd0);     // appended at the end
        send_item(OP_INSERT, 16'h0000, 6'd0);     // placed at the front
        send_item(OP_INSERT, 16'h7FFF, 6'd0);     // placed in the middle
        send_item(OP_INSERT, 16'hFFFF, 6'd0);     // duplicate, last place
        send_item(OP_INSERT, 16'h0000, 6'd0);     // duplicate, first place
        send_item(OP_INSERT, 16'h5555, 6'd0);
        send_item(OP_INSERT, 16'hAAAA, 6'd0);
        send_item(OP_READ,   16'hFFFF, 6'd0);
        send_item(OP_READ,   16'h0000, 6'd5);
        send_item(OP_READ,   16'h0000, 6'd6);     // first index past the end
        send_item(OP_READ,   16'h0000, 6'd63);
        send_item(OP_READ,   16'h0000, 6'h2A);
        send_item(OP_READ,   16'h0000, 6'h15);
        send_item(OP_SPARE,  16'h0000, 6'd2);
        send_item(OP_SPARE,  16'hFFFF, 6'd63);
        send_item(OP_CLEAR,  16'hFFFF, 6'd63);
        send_item(OP_READ,   16'h0000, 6'd0);     // stale entries must not show
        send_item(OP_INSERT, 16'h1234, 6'd0);
        send_item(OP_READ,   16'h0000, 6'd0);
    endtask

    task automatic test_fill_to_capacity;
        logic [15:0] id;
        bit          dup;
        send_item(OP_CLEAR, 16'h0000, 6'd0);
        // descending first, so every insert shifts the whole list
        for (int i = 0; i < SET_DEPTH / 2; i++) begin
            send_item(OP_INSERT, 16'(16'hFFFF - i * 997), 6'd0);
        end
        while (shadow_count < SET_DEPTH) begin
            do begin
                id  = 16'($urandom_range(16'hFFFF));
                dup = 1'b0;
                for (int k = 0; k < shadow_count; k++) if (shadow_ids[k] == id) dup = 1'b1;
            end while (dup);
            send_item(OP_INSERT, id, 6'd0);
        end
        send_item(OP_INSERT, id ^ 16'h0001, 6'd0);
        send_item(OP_INSERT, shadow_ids[10], 6'd0);   // present but full wins
        send_item(OP_READ, 16'h0000, 6'd63);
        send_item(OP_READ, 16'h0000, 6'd0);
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned s_pct,
                                       input int unsigned r_pct);
        logic [1:0]  op;
        logic [15:0] id;
        logic [5:0]  idx;
        logic [15:0] pick;
        int unsigned sel;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int unsigned n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            id  = 16'($urandom_range(16'hFFFF));
            idx = 6'($urandom_range(63));
            if (sel < 1)       op = OP_CLEAR;
            else if (sel < 4)  op = OP_SPARE;
            else if (sel < 34) op = OP_READ;
            else               op = OP_INSERT;
            if (shadow_count > 0) begin
                pick = shadow_ids[$urandom_range(shadow_count - 1)];
                if (op == OP_INSERT) begin
                    sel = $urandom_range(7);
                    if (sel < 2)       id = pick;
                    else if (sel == 2) id = pick + 16'd1;
                    else if (sel == 3) id = pick - 16'd1;
                end else if ($urandom_range(9) < 7) begin
                    idx = 6'($urandom_range(shadow_count - 1));
                end
            end
            send_item(op, id, idx);
        end
    endtask

    task automatic test_output_hold_off;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = 300;
        for (int i = 0; i < 12; i++) begin
            send_item(i % 3 == 0 ? OP_READ : OP_INSERT, 16'($urandom_range(16'hFFFF)),
                      6'($urandom_range(63)));
        end
    endtask

    initial begin
        int drain_wait;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_INSERT;
        s_id           = '0;
        s_index        = '0;
        shadow_count   = 0;
        mismatch_count = 0;
        hold_off_left  = 0;
        send_idle_pct  = 35;
        recv_idle_pct  = 65;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_fill_to_capacity();
        test_random_traffic(420, 35, 65);
        test_random_traffic(420, 65, 35);
        test_random_traffic(420, 0, 0);
        test_output_hold_off();

        @(negedge aclk);
        s_valid <= 1'b0;
        drain_wait = 0;
        while (pending_outcomes.size() != 0 && drain_wait < 5000) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_outcomes.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
